// ----- hw/rtl/wavhp_pkg.sv -----
package wavhp_pkg;

	localparam int unsigned TAG_W  = 32;
	localparam int unsigned TDATA_W = 160;

	// tags as they arrive on the wire, first byte in the lowest bits
	localparam logic [TAG_W-1:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [TAG_W-1:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [TAG_W-1:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [TAG_W-1:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_BASE_SIZE = 32'd16;

	typedef enum logic [3:0] {
		PH_RIFF_TAG  = 4'd0,
		PH_RIFF_SIZE = 4'd1,
		PH_WAVE_TAG  = 4'd2,
		PH_FID       = 4'd3,
		PH_FSIZE     = 4'd4,
		PH_FSKIP     = 4'd5,
		PH_FMT_SIZE  = 4'd6,
		PH_FMT_CH    = 4'd7,
		PH_RATE      = 4'd8,
		PH_BRATE     = 4'd9,
		PH_ALIGN_DEP = 4'd10,
		PH_FEXTRA    = 4'd11,
		PH_DID       = 4'd12,
		PH_DSIZE     = 4'd13,
		PH_DSKIP     = 4'd14,
		PH_DATA_SIZE = 4'd15
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_RIFF = 2'd1,
		ST_NOT_WAVE = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] fmt_code;
		logic [15:0] channel_count;
		logic [31:0] sample_hz;
		logic [31:0] bytes_per_sec;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
	} result_t;

	// parser state; all zeros is the state after reset or restart
	typedef struct packed {
		phase_t      phase;
		logic [1:0]  byte_index;
		logic [31:0] accumulator;
		logic [31:0] skip_remaining;
		logic        tag_mismatch;
		logic [31:0] fmt_extra;
		logic [15:0] held_format;
		logic [15:0] held_channels;
		logic [31:0] held_rate;
		logic [31:0] held_bps;
		logic [15:0] held_align;
		logic [15:0] held_depth;
		logic        finished;
	} parse_state_t;

	// stage handshake between the input register and the rest
	typedef struct packed {
		logic     valid;
		in_beat_t beat;
	} stage_t;

	function automatic logic is_tag_phase(input phase_t ph);
		return (ph == PH_RIFF_TAG) || (ph == PH_WAVE_TAG) ||
			(ph == PH_FID) || (ph == PH_DID);
	endfunction

	function automatic logic is_skip_phase(input phase_t ph);
		return (ph == PH_FSKIP) || (ph == PH_DSKIP) || (ph == PH_FEXTRA);
	endfunction

	function automatic logic [7:0] tag_byte(input phase_t ph, input logic [1:0] idx);
		logic [TAG_W-1:0] tag;
		priority if (ph == PH_WAVE_TAG) begin
			tag = TAG_WAVE;
		end else if (ph == PH_FID) begin
			tag = TAG_FMT;
		end else if (ph == PH_DID) begin
			tag = TAG_DATA;
		end else begin
			tag = TAG_RIFF;
		end
		return tag[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- hw/rtl/wavhp_in_stage.sv -----
module wavhp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
	input  logic                s_axis_tuser,   // [0] first_byte
	input  logic                s_axis_tlast,
	input  logic                advance,
	output wavhp_pkg::stage_t   stage
);

	logic                 valid_s1;
	wavhp_pkg::in_beat_t  beat_s1;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beat_s1.data_byte  <= s_axis_tdata;
			beat_s1.first_byte <= s_axis_tuser;
			beat_s1.last_byte  <= s_axis_tlast;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.beat  = beat_s1;

endmodule

// ----- hw/rtl/wavhp_parse.sv -----
module wavhp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  wavhp_pkg::in_beat_t  beat,
	output logic                 emit,
	output wavhp_pkg::result_t   result
);

	wavhp_pkg::parse_state_t state_q;
	wavhp_pkg::parse_state_t cur;
	wavhp_pkg::parse_state_t nxt;
	wavhp_pkg::status_t      status;
	logic [31:0]             acc_new;
	logic                    bad;

	always_comb begin
		// restart clears everything before the byte is used
		cur     = beat.first_byte ? wavhp_pkg::parse_state_t'('0) : state_q;
		nxt     = cur;
		emit    = 1'b0;
		status  = wavhp_pkg::ST_OK;
		acc_new = {beat.data_byte, cur.accumulator[31:8]};
		bad     = cur.tag_mismatch;

		if (!cur.finished) begin
			if (wavhp_pkg::is_skip_phase(cur.phase)) begin
				if (cur.skip_remaining <= 32'd1) begin
					nxt.skip_remaining = '0;
					nxt.phase = (cur.phase == wavhp_pkg::PH_FSKIP) ?
						wavhp_pkg::PH_FID : wavhp_pkg::PH_DID;
				end else begin
					nxt.skip_remaining = cur.skip_remaining - 32'd1;
				end
			end else begin
				nxt.byte_index  = cur.byte_index + 2'd1;
				nxt.accumulator = acc_new;
				if (wavhp_pkg::is_tag_phase(cur.phase) &&
					(beat.data_byte != wavhp_pkg::tag_byte(cur.phase, cur.byte_index))) begin
					bad = 1'b1;
				end
				nxt.tag_mismatch = bad;

				if (cur.byte_index == 2'd3) begin
					nxt.tag_mismatch = 1'b0;
					unique case (cur.phase)
						wavhp_pkg::PH_RIFF_TAG: begin
							if (bad) begin
								emit   = 1'b1;
								status = wavhp_pkg::ST_NOT_RIFF;
							end else begin
								nxt.phase = wavhp_pkg::PH_RIFF_SIZE;
							end
						end
						wavhp_pkg::PH_RIFF_SIZE: nxt.phase = wavhp_pkg::PH_WAVE_TAG;
						wavhp_pkg::PH_WAVE_TAG: begin
							if (bad) begin
								emit   = 1'b1;
								status = wavhp_pkg::ST_NOT_WAVE;
							end else begin
								nxt.phase = wavhp_pkg::PH_FID;
							end
						end
						wavhp_pkg::PH_FID: begin
							nxt.phase = bad ? wavhp_pkg::PH_FSIZE : wavhp_pkg::PH_FMT_SIZE;
						end
						wavhp_pkg::PH_FSIZE: begin
							if (acc_new == '0) begin
								nxt.phase = wavhp_pkg::PH_FID;
							end else begin
								nxt.skip_remaining = acc_new;
								nxt.phase = wavhp_pkg::PH_FSKIP;
							end
						end
						wavhp_pkg::PH_FMT_SIZE: begin
							nxt.fmt_extra = (acc_new > wavhp_pkg::FMT_BASE_SIZE) ?
								(acc_new - wavhp_pkg::FMT_BASE_SIZE) : '0;
							nxt.phase = wavhp_pkg::PH_FMT_CH;
						end
						wavhp_pkg::PH_FMT_CH: begin
							nxt.held_format   = acc_new[15:0];
							nxt.held_channels = acc_new[31:16];
							nxt.phase = wavhp_pkg::PH_RATE;
						end
						wavhp_pkg::PH_RATE: begin
							nxt.held_rate = acc_new;
							nxt.phase = wavhp_pkg::PH_BRATE;
						end
						wavhp_pkg::PH_BRATE: begin
							nxt.held_bps = acc_new;
							nxt.phase = wavhp_pkg::PH_ALIGN_DEP;
						end
						wavhp_pkg::PH_ALIGN_DEP: begin
							nxt.held_align = acc_new[15:0];
							nxt.held_depth = acc_new[31:16];
							// pass over fmt bytes beyond the basic sixteen
							if (cur.fmt_extra == '0) begin
								nxt.phase = wavhp_pkg::PH_DID;
							end else begin
								nxt.skip_remaining = cur.fmt_extra;
								nxt.phase = wavhp_pkg::PH_FEXTRA;
							end
						end
						wavhp_pkg::PH_DID: begin
							nxt.phase = bad ? wavhp_pkg::PH_DSIZE : wavhp_pkg::PH_DATA_SIZE;
						end
						wavhp_pkg::PH_DSIZE: begin
							if (acc_new == '0) begin
								nxt.phase = wavhp_pkg::PH_DID;
							end else begin
								nxt.skip_remaining = acc_new;
								nxt.phase = wavhp_pkg::PH_DSKIP;
							end
						end
						wavhp_pkg::PH_DATA_SIZE: begin
							emit   = 1'b1;
							status = wavhp_pkg::ST_OK;
						end
						default: ;
					endcase
				end
			end

			if (!emit && beat.last_byte) begin
				emit   = 1'b1;
				status = wavhp_pkg::ST_TRUNC;
			end
			if (emit) begin
				nxt.finished = 1'b1;
			end
		end
	end

	always_comb begin
		result = '0;
		result.status = status;
		if (status == wavhp_pkg::ST_OK) begin
			result.fmt_code      = nxt.held_format;
			result.channel_count = nxt.held_channels;
			result.sample_hz     = nxt.held_rate;
			result.bytes_per_sec = nxt.held_bps;
			result.frame_bytes   = nxt.held_align;
			result.sample_bits   = nxt.held_depth;
			result.data_size     = acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

endmodule

// ----- hw/rtl/wavhp_out_stage.sv -----
module wavhp_out_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  wavhp_pkg::result_t                  result,
	output logic                                room,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [wavhp_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic [1:0]                          m_axis_tuser
);

	logic               valid_q;
	wavhp_pkg::result_t result_q;

	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = result_q.status;
	assign m_axis_tdata  = {result_q.data_size, result_q.sample_bits, result_q.frame_bytes,
		result_q.bytes_per_sec, result_q.sample_hz, result_q.channel_count,
		result_q.fmt_code};

endmodule

// ----- hw/rtl/wav_header_parser_top.sv -----
// WAV header parser.
// Input stream: one byte of the file per beat. s_axis_tuser marks the first byte
// of a file and restarts the parser; s_axis_tlast marks the final byte.
// Output stream: at most one beat per file. m_axis_tuser carries the status
// (ok, not RIFF, not WAVE, truncated); m_axis_tdata carries the captured format
// fields and data chunk size, all zero unless the status is ok.
// Bytes after a result are dropped until the next first byte.
// Throughput: one byte per cycle while no result is stalled at the output; the
// parse logic sits between the input register and the result register.
// A result is registered: the byte that completes it is held in the input register,
// then the result enters the result register, which drives m_axis_tvalid.
// Reset: arst_n clears the parser to wait for the RIFF tag and empties both
// registers; no result is pending after reset.
// Stall: while m_axis_tready is low a waiting result holds, the byte in the input
// register waits, and s_axis_tready drops only once both registers are full.
module wav_header_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
	input  logic                                s_axis_tuser,   // [0] first_byte
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] fmt_code, [31:16] channel_count, [63:32] sample_hz,
	// [95:64] bytes_per_sec, [111:96] frame_bytes, [127:112] sample_bits,
	// [159:128] data_size
	output logic [wavhp_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic [1:0]                          m_axis_tuser    // [1:0] status
);

	wavhp_pkg::stage_t  stage;
	wavhp_pkg::result_t result;
	logic               emit;
	logic               room;
	logic               advance;

	assign advance = stage.valid && room;

	wavhp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.advance       (advance),
		.stage         (stage)
	);

	wavhp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (stage.beat),
		.emit    (emit),
		.result  (result)
	);

	wavhp_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && emit),
		.result        (result),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ----- hw/rtl/wavhp_checker.sv -----
module wavhp_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [wavhp_pkg::TDATA_W-1:0]       m_axis_tdata,
	input  logic [1:0]                          m_axis_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// fields are zero on any error status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != wavhp_pkg::ST_OK) |-> (m_axis_tdata == '0))
		else $error("fields set on an error result");

	// a fresh result comes from a byte accepted on the input, through the input register
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a causing byte");

endmodule

bind wav_header_parser_top wavhp_checker u_chk (.*);

// ----- dv/wav_header_checker.sv -----
`timescale 1ns / 100ps

module wav_header_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
	input  logic                          s_axis_tuser,   // [0] first_byte
	input  logic                          s_axis_tlast,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] fmt_code, [31:16] channel_count, [63:32] sample_hz,
	// [95:64] bytes_per_sec, [111:96] frame_bytes, [127:112] sample_bits,
	// [159:128] data_size
	input  logic [wavhp_pkg::TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]                    m_axis_tuser,   // [1:0] status
	output int                            fail_count,
	output int                            hdr_pending
);

	wavhp_pkg::parse_state_t parser;
	wavhp_pkg::result_t      hdr_expected[$];
	int                      mism = 0;

	assign fail_count = mism;

	task automatic advance_parser(input logic [7:0] b, input logic first, input logic last);
		logic [1:0]         idx;
		logic [31:0]        tag_word;
		logic               is_tag;
		logic               bad;
		logic               emit;
		wavhp_pkg::status_t st;
		wavhp_pkg::result_t res;
		emit = 1'b0;
		st = wavhp_pkg::ST_OK;
		if (first) begin
			parser = '0;
		end else if (parser.finished) begin
			return;
		end
		if (parser.phase == wavhp_pkg::PH_FSKIP || parser.phase == wavhp_pkg::PH_DSKIP ||
				parser.phase == wavhp_pkg::PH_FEXTRA) begin
			if (parser.skip_remaining <= 32'd1) begin
				parser.skip_remaining = '0;
				parser.phase = (parser.phase == wavhp_pkg::PH_FSKIP) ?
					wavhp_pkg::PH_FID : wavhp_pkg::PH_DID;
			end else begin
				parser.skip_remaining = parser.skip_remaining - 32'd1;
			end
		end else begin
			idx = parser.byte_index;
			parser.byte_index = idx + 2'd1;
			// little-endian: newest byte enters at the top
			parser.accumulator = {b, parser.accumulator[31:8]};
			is_tag = 1'b1;
			case (parser.phase)
				wavhp_pkg::PH_RIFF_TAG: tag_word = wavhp_pkg::TAG_RIFF;
				wavhp_pkg::PH_WAVE_TAG: tag_word = wavhp_pkg::TAG_WAVE;
				wavhp_pkg::PH_FID:      tag_word = wavhp_pkg::TAG_FMT;
				wavhp_pkg::PH_DID:      tag_word = wavhp_pkg::TAG_DATA;
				default: begin
					tag_word = '0;
					is_tag = 1'b0;
				end
			endcase
			if (is_tag && b != tag_word[{idx, 3'b000} +: 8]) begin
				parser.tag_mismatch = 1'b1;
			end
			if (idx == 2'd3) begin
				bad = parser.tag_mismatch;
				parser.tag_mismatch = 1'b0;
				case (parser.phase)
					wavhp_pkg::PH_RIFF_TAG: begin
						if (bad) begin
							emit = 1'b1;
							st = wavhp_pkg::ST_NOT_RIFF;
						end else begin
							parser.phase = wavhp_pkg::PH_RIFF_SIZE;
						end
					end
					wavhp_pkg::PH_RIFF_SIZE: parser.phase = wavhp_pkg::PH_WAVE_TAG;
					wavhp_pkg::PH_WAVE_TAG: begin
						if (bad) begin
							emit = 1'b1;
							st = wavhp_pkg::ST_NOT_WAVE;
						end else begin
							parser.phase = wavhp_pkg::PH_FID;
						end
					end
					wavhp_pkg::PH_FID: begin
						parser.phase = bad ? wavhp_pkg::PH_FSIZE : wavhp_pkg::PH_FMT_SIZE;
					end
					wavhp_pkg::PH_FSIZE: begin
						if (parser.accumulator == '0) begin
							parser.phase = wavhp_pkg::PH_FID;
						end else begin
							parser.skip_remaining = parser.accumulator;
							parser.phase = wavhp_pkg::PH_FSKIP;
						end
					end
					wavhp_pkg::PH_FMT_SIZE: begin
						parser.fmt_extra = (parser.accumulator > wavhp_pkg::FMT_BASE_SIZE) ?
							parser.accumulator - wavhp_pkg::FMT_BASE_SIZE : '0;
						parser.phase = wavhp_pkg::PH_FMT_CH;
					end
					wavhp_pkg::PH_FMT_CH: begin
						parser.held_format = parser.accumulator[15:0];
						parser.held_channels = parser.accumulator[31:16];
						parser.phase = wavhp_pkg::PH_RATE;
					end
					wavhp_pkg::PH_RATE: begin
						parser.held_rate = parser.accumulator;
						parser.phase = wavhp_pkg::PH_BRATE;
					end
					wavhp_pkg::PH_BRATE: begin
						parser.held_bps = parser.accumulator;
						parser.phase = wavhp_pkg::PH_ALIGN_DEP;
					end
					wavhp_pkg::PH_ALIGN_DEP: begin
						parser.held_align = parser.accumulator[15:0];
						parser.held_depth = parser.accumulator[31:16];
						if (parser.fmt_extra == '0) begin
							parser.phase = wavhp_pkg::PH_DID;
						end else begin
							parser.skip_remaining = parser.fmt_extra;
							parser.phase = wavhp_pkg::PH_FEXTRA;
						end
					end
					wavhp_pkg::PH_DID: begin
						parser.phase = bad ? wavhp_pkg::PH_DSIZE : wavhp_pkg::PH_DATA_SIZE;
					end
					wavhp_pkg::PH_DSIZE: begin
						if (parser.accumulator == '0) begin
							parser.phase = wavhp_pkg::PH_DID;
						end else begin
							parser.skip_remaining = parser.accumulator;
							parser.phase = wavhp_pkg::PH_DSKIP;
						end
					end
					wavhp_pkg::PH_DATA_SIZE: emit = 1'b1;
					default: begin
					end
				endcase
			end
		end
		// a completed header or bad tag wins over truncation
		if (!emit && last) begin
			emit = 1'b1;
			st = wavhp_pkg::ST_TRUNC;
		end
		if (emit) begin
			parser.finished = 1'b1;
			res = '0;
			res.status = st;
			if (st == wavhp_pkg::ST_OK) begin
				res.fmt_code = parser.held_format;
				res.channel_count = parser.held_channels;
				res.sample_hz = parser.held_rate;
				res.bytes_per_sec = parser.held_bps;
				res.frame_bytes = parser.held_align;
				res.sample_bits = parser.held_depth;
				res.data_size = parser.accumulator;
			end
			hdr_expected.push_back(res);
		end
	endtask

	task automatic cmp_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected 0x%08h actual 0x%08h", $time, what, want, got);
			mism++;
		end
	endtask

	task automatic check_result();
		wavhp_pkg::result_t want;
		if (hdr_expected.size() == 0) begin
			$display("%0t unexpected result beat: status %0d tdata 0x%h",
				$time, m_axis_tuser, m_axis_tdata);
			mism++;
			return;
		end
		want = hdr_expected.pop_front();
		cmp_field("status", {30'd0, want.status}, {30'd0, m_axis_tuser});
		cmp_field("fmt_code", {16'd0, want.fmt_code}, {16'd0, m_axis_tdata[15:0]});
		cmp_field("channel_count", {16'd0, want.channel_count},
			{16'd0, m_axis_tdata[31:16]});
		cmp_field("sample_hz", want.sample_hz, m_axis_tdata[63:32]);
		cmp_field("bytes_per_sec", want.bytes_per_sec, m_axis_tdata[95:64]);
		cmp_field("frame_bytes", {16'd0, want.frame_bytes}, {16'd0, m_axis_tdata[111:96]});
		cmp_field("sample_bits", {16'd0, want.sample_bits}, {16'd0, m_axis_tdata[127:112]});
		cmp_field("data_size", want.data_size, m_axis_tdata[159:128]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parser = '0;
			hdr_expected.delete();
			hdr_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_parser(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			end
			hdr_pending <= hdr_expected.size();
		end
	end

endmodule

// ----- dv/tb_wav_header_parser_top.sv -----
`timescale 1ns / 100ps

module tb_wav_header_parser_top;

	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam int unsigned BODY_TARGET = 1050;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          s_axis_tlast = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [wavhp_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                    m_axis_tuser;

	int          fail_count;
	int          hdr_pending;
	int          src_idle_pct = 30;
	int          sink_idle_pct = 76;
	int unsigned cyc;
	logic [7:0]  wav_img[$];

	wav_header_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	wav_header_checker hdr_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.hdr_pending   (hdr_pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
			@(posedge clk);
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_img(input logic with_last);
		for (int i = 0; i < wav_img.size(); i++) begin
			send_byte(wav_img[i], i == 0, with_last && (i == wav_img.size() - 1));
		end
	endtask

	// hold the sender off until every predicted result has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (hdr_pending != 0);
	endtask

	task automatic put_le32(input logic [31:0] w);
		for (int i = 0; i < 4; i++) begin
			wav_img.push_back(w[8*i +: 8]);
		end
	endtask

	// broken files may claim more payload than they carry
	function automatic int pay_len(input logic [31:0] size, input bit clean);
		if (clean) begin
			return int'(size);
		end
		return int'($urandom_range(0, (size > 32'd6) ? 6 : int'(size)));
	endfunction

	task automatic put_chunk(input logic [31:0] tag, input bit clean);
		logic [31:0] csize;
		if (clean || $urandom_range(1) == 0) begin
			csize = $urandom_range(0, 5);
		end else begin
			csize = $urandom;
		end
		put_le32(tag);
		put_le32(csize);
		repeat (pay_len(csize, clean)) wav_img.push_back(8'($urandom));
	endtask

	task automatic build_wav(input bit clean, output int body_len);
		logic [31:0] fsize;
		int          pos;
		int          cut;
		wav_img.delete();
		put_le32(wavhp_pkg::TAG_RIFF);
		put_le32($urandom);
		put_le32(wavhp_pkg::TAG_WAVE);
		repeat ($urandom_range(0, 2)) begin
			put_chunk(($urandom_range(3) == 0) ? wavhp_pkg::TAG_DATA : 32'($urandom), clean);
		end
		case ($urandom_range(3))
			0, 1: fsize = wavhp_pkg::FMT_BASE_SIZE;
			2: fsize = $urandom_range(0, 15);
			default: begin
				fsize = clean ? wavhp_pkg::FMT_BASE_SIZE + 32'($urandom_range(1, 4)) :
					32'($urandom);
			end
		endcase
		put_le32(wavhp_pkg::TAG_FMT);
		put_le32(fsize);
		repeat (16) wav_img.push_back(8'($urandom));
		if (fsize > wavhp_pkg::FMT_BASE_SIZE) begin
			repeat (pay_len(fsize - wavhp_pkg::FMT_BASE_SIZE, clean)) begin
				wav_img.push_back(8'($urandom));
			end
		end
		repeat ($urandom_range(0, 2)) begin
			put_chunk(($urandom_range(3) == 0) ? wavhp_pkg::TAG_FMT : 32'($urandom), clean);
		end
		put_le32(wavhp_pkg::TAG_DATA);
		put_le32($urandom);
		body_len = wav_img.size();
		if (clean) begin
			// trailing bytes land after the result and get dropped
			repeat ($urandom_range(0, 3)) wav_img.push_back(8'($urandom));
		end else begin
			if ($urandom_range(1) == 0) begin
				pos = int'($urandom_range(0, wav_img.size() - 1));
				wav_img[pos] = wav_img[pos] ^ 8'($urandom_range(1, 255));
			end
			if ($urandom_range(2) != 0) begin
				cut = int'($urandom_range(1, wav_img.size()));
				while (wav_img.size() > cut) void'(wav_img.pop_back());
			end
			body_len = wav_img.size();
		end
	endtask

	initial begin
		int blen;
		int body_total;
		int stage;
		int cur_stage;
		bit clean;

		body_total = 0;
		cur_stage = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no restart after reset; last byte completes a bad RIFF tag
		send_byte(wavhp_pkg::TAG_RIFF[7:0], 1'b0, 1'b0);
		send_byte(wavhp_pkg::TAG_RIFF[15:8], 1'b0, 1'b0);
		send_byte(wavhp_pkg::TAG_RIFF[23:16], 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		// dropped: parser already finished
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		// max RIFF size, then a bad WAVE tag
		wav_img.delete();
		put_le32(wavhp_pkg::TAG_RIFF);
		put_le32(32'hFFFF_FFFF);
		put_le32(wavhp_pkg::TAG_WAVE ^ 32'h8000_0000);
		send_img(1'b0);
		// restart in mid tag, then truncate on the first byte
		send_byte(wavhp_pkg::TAG_RIFF[7:0], 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		// one-byte file
		send_byte(wavhp_pkg::TAG_RIFF[7:0], 1'b1, 1'b1);

		while (body_total < BODY_TARGET) begin
			stage = (body_total < BODY_TARGET / 3) ? 0 :
				(body_total < 2 * BODY_TARGET / 3) ? 1 : 2;
			if (stage != cur_stage) begin
				drain_results();
				cur_stage = stage;
				src_idle_pct = (stage == 1) ? 76 : 0;
				sink_idle_pct = (stage == 1) ? 30 : 0;
			end
			clean = ($urandom_range(9) < 7);
			build_wav(clean, blen);
			send_img(clean ? ($urandom_range(9) != 0) : 1'b1);
			body_total += blen;
			if ($urandom_range(19) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (hdr_pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && hdr_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_in_stage.sv
hw/rtl/wavhp_parse.sv
hw/rtl/wavhp_out_stage.sv
hw/rtl/wav_header_parser_top.sv
hw/rtl/wavhp_checker.sv
dv/wav_header_checker.sv
dv/tb_wav_header_parser_top.sv
